>>> rtl/pdt_pkg.sv
// Package for the prescaled down timer: item and result types, command and
// register codes, bit positions and default widths.
// No dependencies.
package pdt_pkg;

  localparam int DEF_COUNTER_WIDTH   = 32;
  localparam int DEF_PRESCALER_WIDTH = 8;
  localparam int DIV_WIDTH           = 7;
  localparam int CSEL_WIDTH          = 3;
  localparam int CTL_WIDTH           = 4;
  localparam int DATA_WIDTH          = 32;
  localparam int IN_TDATA_WIDTH      = 40;
  localparam int OUT_TDATA_WIDTH     = 40;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  localparam logic [2:0] REG_PRESCALER = 3'd0;
  localparam logic [2:0] REG_CLK_SEL   = 3'd1;
  localparam logic [2:0] REG_CONTROL   = 3'd2;
  localparam logic [2:0] REG_CNT_BUF   = 3'd3;
  localparam logic [2:0] REG_COMPARE   = 3'd4;
  localparam logic [2:0] REG_COUNT     = 3'd5;
  localparam logic [2:0] REG_INTERRUPT = 3'd6;

  localparam int CTL_START  = 0;
  localparam int CTL_MANUAL = 1;
  localparam int CTL_AUTO   = 3;
  localparam int INT_EN     = 0;
  localparam int INT_ST     = 5;

  typedef struct packed {
    logic [1:0]            command;
    logic [2:0]            reg_index;
    logic [DATA_WIDTH-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_data;
    logic                  irq;
  } result_t;

  // Terminal count of the power-of-two divider: 2^sel - 1.
  function automatic logic [DIV_WIDTH-1:0] div_last(input logic [CSEL_WIDTH-1:0] sel);
    logic [DIV_WIDTH:0] one;
    one = (DIV_WIDTH+1)'(1) << sel;
    return DIV_WIDTH'(one - (DIV_WIDTH+1)'(1));
  endfunction

endpackage

>>> rtl/prescaled_down_timer_top.sv
// Top level of the prescaled down timer: input register, timer core and
// result register. Depends on pdt_pkg, pdt_in_reg, pdt_core, pdt_out_reg.
//
// Usage: each item on the slave stream is a tick, a register read or a
// register write; every item yields exactly one result item on the master
// stream carrying the read data (zero for ticks and writes) and the
// interrupt line after the item's update.
// A result passes from the input register through the timer core into the
// result register, where it is offered on the master stream; an item waits
// in the input register while the result register is full and not taken.
// Throughput: one item per cycle while the receiver takes results; the whole
// timer update for an item is a single pass of logic between the input
// register and the result register, so the state is ready for the next item.
// Reset (rst, synchronous, active high) clears all timer registers to zero:
// stopped, bypass divider, interrupts disabled and clear, both streams empty.
// When the receiver holds m_tready low the result waits in the result
// register; one more item is taken into the input register, after which
// s_tready drops until the receiver takes the result.
module prescaled_down_timer_top
  import pdt_pkg::*;
#(
  parameter int COUNTER_WIDTH   = DEF_COUNTER_WIDTH,
  parameter int PRESCALER_WIDTH = DEF_PRESCALER_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // command [1:0], reg_index [4:2], write_data [36:5], zero [39:37]
  input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // read_data [31:0], irq [32], zero [39:33]
  output logic [OUT_TDATA_WIDTH-1:0] m_tdata
);

  logic    in_valid;
  logic    can_load;
  logic    fire;
  item_t   item;
  result_t result;

  assign fire = in_valid && can_load;

  pdt_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .advance  (can_load),
    .valid    (in_valid),
    .item     (item)
  );

  pdt_core #(
    .COUNTER_WIDTH   (COUNTER_WIDTH),
    .PRESCALER_WIDTH (PRESCALER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  pdt_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .result   (result),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> rtl/pdt_in_reg.sv
// Input register of the prescaled down timer: holds one incoming item.
// Depends on pdt_pkg.
module pdt_in_reg
  import pdt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_TDATA_WIDTH-1:0] s_tdata,
  input  logic                      advance,
  output logic                      valid,
  output item_t                     item
);

  logic [IN_TDATA_WIDTH-1:0] data;

  // The held item leaves whenever the core takes it, so a new one can enter.
  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data <= s_tdata;
    end
  end

  always_comb begin
    item.command    = data[1:0];
    item.reg_index  = data[4:2];
    item.write_data = data[36:5];
  end

endmodule

>>> rtl/pdt_core.sv
// Timer state and the per-item update: tick divider chain, register reads and
// writes, expiry handling. Depends on pdt_pkg.
module pdt_core
  import pdt_pkg::*;
#(
  parameter int COUNTER_WIDTH   = DEF_COUNTER_WIDTH,
  parameter int PRESCALER_WIDTH = DEF_PRESCALER_WIDTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  logic [PRESCALER_WIDTH-1:0] prescale_value, prescale_value_next;
  logic [PRESCALER_WIDTH-1:0] prescale_count, prescale_count_next;
  logic [CSEL_WIDTH-1:0]      clock_select, clock_select_next;
  logic [CTL_WIDTH-1:0]       control_bits, control_bits_next;
  logic [COUNTER_WIDTH-1:0]   count_buffer, count_buffer_next;
  logic [COUNTER_WIDTH-1:0]   compare_buffer, compare_buffer_next;
  logic [COUNTER_WIDTH-1:0]   down_counter, down_counter_next;
  logic [DIV_WIDTH-1:0]       divider_count, divider_count_next;
  logic                       int_enable, int_enable_next;
  logic                       int_status, int_status_next;

  logic                  pre_pass;
  logic                  div_pass;
  logic                  expire;
  logic [DIV_WIDTH-1:0]  last;
  logic [DATA_WIDTH-1:0] rd;

  always_comb begin
    prescale_value_next = prescale_value;
    prescale_count_next = prescale_count;
    clock_select_next   = clock_select;
    control_bits_next   = control_bits;
    count_buffer_next   = count_buffer;
    compare_buffer_next = compare_buffer;
    down_counter_next   = down_counter;
    divider_count_next  = divider_count;
    int_enable_next     = int_enable;
    int_status_next     = int_status;
    rd                  = '0;
    pre_pass            = 1'b0;
    div_pass            = 1'b0;
    expire              = 1'b0;
    last                = div_last(clock_select);

    unique case (item.command)
      CMD_TICK: begin
        if (control_bits[CTL_START]) begin
          if (prescale_count >= prescale_value) begin
            prescale_count_next = '0;
            pre_pass            = 1'b1;
          end else begin
            prescale_count_next = prescale_count + PRESCALER_WIDTH'(1);
          end
          if (pre_pass) begin
            if (clock_select == '0) begin
              div_pass = 1'b1;
            end else if (divider_count >= last) begin
              divider_count_next = '0;
              div_pass           = 1'b1;
            end else begin
              divider_count_next = divider_count + DIV_WIDTH'(1);
            end
          end
          if (div_pass) begin
            // A counter at zero expires at once; one at one expires after its step.
            expire = (down_counter == '0) || (down_counter == COUNTER_WIDTH'(1));
            if (!expire) begin
              down_counter_next = down_counter - COUNTER_WIDTH'(1);
            end else begin
              int_status_next = 1'b1;
              if (control_bits[CTL_AUTO]) begin
                down_counter_next = count_buffer;
              end else begin
                down_counter_next               = '0;
                control_bits_next[CTL_START]    = 1'b0;
              end
            end
          end
        end
      end
      CMD_READ: begin
        unique case (item.reg_index)
          REG_PRESCALER: rd = DATA_WIDTH'(prescale_value);
          REG_CLK_SEL:   rd = DATA_WIDTH'(clock_select);
          REG_CONTROL:   rd = DATA_WIDTH'(control_bits);
          REG_CNT_BUF:   rd = DATA_WIDTH'(count_buffer);
          REG_COMPARE:   rd = DATA_WIDTH'(compare_buffer);
          REG_COUNT:     rd = DATA_WIDTH'(down_counter);
          REG_INTERRUPT: begin
            rd[INT_EN] = int_enable;
            rd[INT_ST] = int_status;
          end
          default:       rd = '0;
        endcase
      end
      CMD_WRITE: begin
        unique case (item.reg_index)
          REG_PRESCALER: prescale_value_next = item.write_data[PRESCALER_WIDTH-1:0];
          REG_CLK_SEL:   clock_select_next   = item.write_data[CSEL_WIDTH-1:0];
          REG_CONTROL: begin
            control_bits_next = item.write_data[CTL_WIDTH-1:0];
            if (item.write_data[CTL_MANUAL]) begin
              down_counter_next   = count_buffer;
              prescale_count_next = '0;
              divider_count_next  = '0;
            end
          end
          REG_CNT_BUF:   count_buffer_next   = item.write_data[COUNTER_WIDTH-1:0];
          REG_COMPARE:   compare_buffer_next = item.write_data[COUNTER_WIDTH-1:0];
          REG_INTERRUPT: begin
            int_enable_next = item.write_data[INT_EN];
            if (item.write_data[INT_ST]) begin
              int_status_next = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    result.read_data = rd;
    result.irq       = int_status_next & int_enable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_value <= '0;
      prescale_count <= '0;
      clock_select   <= '0;
      control_bits   <= '0;
      count_buffer   <= '0;
      compare_buffer <= '0;
      down_counter   <= '0;
      divider_count  <= '0;
      int_enable     <= 1'b0;
      int_status     <= 1'b0;
    end else if (fire) begin
      prescale_value <= prescale_value_next;
      prescale_count <= prescale_count_next;
      clock_select   <= clock_select_next;
      control_bits   <= control_bits_next;
      count_buffer   <= count_buffer_next;
      compare_buffer <= compare_buffer_next;
      down_counter   <= down_counter_next;
      divider_count  <= divider_count_next;
      int_enable     <= int_enable_next;
      int_status     <= int_status_next;
    end
  end

endmodule

>>> rtl/pdt_out_reg.sv
// Result register of the prescaled down timer: holds one result item until
// the receiver takes it. Depends on pdt_pkg.
module pdt_out_reg
  import pdt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  result_t                    result,
  output logic                       can_load,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [OUT_TDATA_WIDTH-1:0] m_tdata
);

  result_t held;

  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= result;
    end
  end

  assign m_tdata = {{(OUT_TDATA_WIDTH-DATA_WIDTH-1){1'b0}}, held.irq, held.read_data};

endmodule

>>> tb/sv/pdt_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the prescaled down timer: watches both streams, keeps its own
// copy of the timer registers and compares every result with its prediction.
// Depends on pdt_pkg.
module pdt_result_checker
  import pdt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  // command [1:0], reg_index [4:2], write_data [36:5], zero [39:37]
  input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  // read_data [31:0], irq [32], zero [39:33]
  input  logic [OUT_TDATA_WIDTH-1:0] m_tdata,
  output int                         mismatches,
  output int                         outstanding
);

  typedef struct {
    logic [DATA_WIDTH-1:0] read_data;
    logic                  irq;
  } timer_result_t;

  timer_result_t expected_results[$];

  logic [DEF_PRESCALER_WIDTH-1:0] pre_val;
  logic [DEF_PRESCALER_WIDTH-1:0] pre_cnt;
  logic [CSEL_WIDTH-1:0]          clk_sel;
  logic [DIV_WIDTH-1:0]           div_cnt;
  logic [CTL_WIDTH-1:0]           ctl;
  logic [DEF_COUNTER_WIDTH-1:0]   cnt_buf;
  logic [DEF_COUNTER_WIDTH-1:0]   cmp_buf;
  logic [DEF_COUNTER_WIDTH-1:0]   counter;
  logic                           int_en;
  logic                           int_st;

  function automatic void clear_timer();
    pre_val = '0;
    pre_cnt = '0;
    clk_sel = '0;
    div_cnt = '0;
    ctl     = '0;
    cnt_buf = '0;
    cmp_buf = '0;
    counter = '0;
    int_en  = 1'b0;
    int_st  = 1'b0;
  endfunction

  function automatic void count_tick();
    logic [DIV_WIDTH-1:0] last;
    if (!ctl[CTL_START]) return;
    // A count at or above a freshly lowered terminal value wraps and passes the tick on.
    if (pre_cnt >= pre_val) begin
      pre_cnt = '0;
    end else begin
      pre_cnt = pre_cnt + 1'b1;
      return;
    end
    if (clk_sel != '0) begin
      last = DIV_WIDTH'((8'd1 << clk_sel) - 8'd1);
      if (div_cnt >= last) begin
        div_cnt = '0;
      end else begin
        div_cnt = div_cnt + 1'b1;
        return;
      end
    end
    // A counter that is already zero expires without decrementing.
    if (counter != '0) begin
      counter = counter - 1'b1;
      if (counter != '0) return;
    end
    int_st = 1'b1;
    if (ctl[CTL_AUTO]) counter = cnt_buf;
    else ctl[CTL_START] = 1'b0;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] read_reg(input logic [2:0] idx);
    logic [DATA_WIDTH-1:0] v;
    v = '0;
    case (idx)
      REG_PRESCALER: v = DATA_WIDTH'(pre_val);
      REG_CLK_SEL:   v = DATA_WIDTH'(clk_sel);
      REG_CONTROL:   v = DATA_WIDTH'(ctl);
      REG_CNT_BUF:   v = cnt_buf;
      REG_COMPARE:   v = cmp_buf;
      REG_COUNT:     v = counter;
      REG_INTERRUPT: begin
        v[INT_EN] = int_en;
        v[INT_ST] = int_st;
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic void write_reg(input logic [2:0] idx, input logic [DATA_WIDTH-1:0] data);
    case (idx)
      REG_PRESCALER: pre_val = data[DEF_PRESCALER_WIDTH-1:0];
      REG_CLK_SEL:   clk_sel = data[CSEL_WIDTH-1:0];
      REG_CONTROL: begin
        ctl = data[CTL_WIDTH-1:0];
        if (data[CTL_MANUAL]) begin
          counter = cnt_buf;
          pre_cnt = '0;
          div_cnt = '0;
        end
      end
      REG_CNT_BUF:   cnt_buf = data[DEF_COUNTER_WIDTH-1:0];
      REG_COMPARE:   cmp_buf = data[DEF_COUNTER_WIDTH-1:0];
      REG_INTERRUPT: begin
        int_en = data[INT_EN];
        if (data[INT_ST]) int_st = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic timer_result_t step_timer(input logic [IN_TDATA_WIDTH-1:0] raw);
    timer_result_t res;
    logic [1:0] cmd;
    logic [2:0] idx;
    logic [DATA_WIDTH-1:0] data;
    cmd = raw[1:0];
    idx = raw[4:2];
    data = raw[36:5];
    res.read_data = '0;
    case (cmd)
      CMD_TICK:  count_tick();
      CMD_READ:  res.read_data = read_reg(idx);
      CMD_WRITE: write_reg(idx, data);
      default: ;
    endcase
    res.irq = int_st & int_en;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    timer_result_t got;
    timer_result_t want;
    if (rst) begin
      clear_timer();
      expected_results.delete();
    end else begin
      // Compare before predicting: an item accepted at this edge cannot have its result here.
      if (m_tvalid && m_tready) begin
        got.read_data = m_tdata[31:0];
        got.irq = m_tdata[32];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, read_data %h irq %b", $time,
                   got.read_data, got.irq);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h got %h", $time,
                     want.read_data, got.read_data);
            mismatches++;
          end
          if (got.irq !== want.irq) begin
            $display("%0t: irq expected %b got %b", $time, want.irq, got.irq);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) expected_results.push_back(step_timer(s_tdata));
    end
    outstanding = expected_results.size();
  end

endmodule

>>> tb/sv/prescaled_down_timer_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the prescaled down timer: clock, reset, item stimulus and
// receiver back-pressure. Depends on pdt_pkg, prescaled_down_timer_top, pdt_result_checker.
module prescaled_down_timer_top_tb
  import pdt_pkg::*;
();

  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam logic [2:0]  REG_UNUSED   = 3'd7;
  localparam logic [31:0] CTL_START_M  = 32'd1 << CTL_START;
  localparam logic [31:0] CTL_MANUAL_M = 32'd1 << CTL_MANUAL;
  localparam logic [31:0] CTL_INVERT_M = 32'd4;
  localparam logic [31:0] CTL_AUTO_M   = 32'd1 << CTL_AUTO;
  localparam logic [31:0] INT_EN_M     = 32'd1 << INT_EN;
  localparam logic [31:0] INT_ST_M     = 32'd1 << INT_ST;
  localparam int          RANDOM_ITEMS = 1450;

  logic                       clk;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [IN_TDATA_WIDTH-1:0]  s_tdata;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [OUT_TDATA_WIDTH-1:0] m_tdata;
  int                         mismatches;
  int                         outstanding;
  int                         items_sent;

  prescaled_down_timer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  pdt_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Mostly back-to-back, sometimes short gaps, rarely long ones.
  function automatic int idle_len(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] reg_value(input logic [2:0] idx);
    if ($urandom_range(0, 3) == 0) return $urandom();
    case (idx)
      REG_PRESCALER: return $urandom_range(0, 3);
      REG_CLK_SEL:   return $urandom_range(0, 7);
      REG_CONTROL:   return $urandom_range(0, 15);
      REG_CNT_BUF:   return $urandom_range(0, 12);
      REG_INTERRUPT: return $urandom() & (INT_EN_M | INT_ST_M);
      default:       return $urandom();
    endcase
  endfunction

  // After an item is taken, valid stays high until the next call or drain decides
  // what it does, so it gets only one assignment in that time step.
  task automatic send_item(input logic [1:0] cmd, input logic [2:0] idx,
                           input logic [31:0] data);
    int gap;
    gap = idle_len((items_sent / 150) % 4 == 1);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, data, idx, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
  endtask

  // Program a short count and let it run, with reads and interrupt clears mixed in.
  task automatic run_program();
    int n_ticks;
    int r;
    logic [31:0] ctl_word;
    send_item(CMD_WRITE, REG_PRESCALER, $urandom_range(0, 2));
    send_item(CMD_WRITE, REG_CLK_SEL, $urandom_range(0, 2));
    send_item(CMD_WRITE, REG_CNT_BUF, $urandom_range(0, 6));
    if ($urandom_range(0, 1))
      send_item(CMD_WRITE, REG_INTERRUPT, $urandom() & (INT_EN_M | INT_ST_M) | INT_EN_M);
    ctl_word = CTL_START_M | CTL_MANUAL_M | ($urandom() & CTL_INVERT_M);
    if ($urandom_range(0, 1)) ctl_word = ctl_word | CTL_AUTO_M;
    send_item(CMD_WRITE, REG_CONTROL, ctl_word);
    n_ticks = $urandom_range(8, 40);
    repeat (n_ticks) begin
      r = $urandom_range(0, 9);
      if (r < 7)
        send_item(CMD_TICK, 3'($urandom_range(0, 7)), $urandom());
      else if (r < 9)
        send_item(CMD_READ, 3'($urandom_range(0, 7)), $urandom());
      else
        send_item(CMD_WRITE, REG_INTERRUPT, $urandom());
    end
  endtask

  task automatic run_noise();
    int n;
    logic [2:0] idx;
    n = $urandom_range(3, 10);
    repeat (n) begin
      idx = 3'($urandom_range(0, 7));
      send_item(2'($urandom_range(0, 3)), idx, reg_value(idx));
    end
  endtask

  initial begin
    int target;
    bit paused;
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    items_sent = 0;
    paused     = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wide values are cut to each register's width; count and unused writes do nothing.
    send_item(CMD_WRITE, REG_PRESCALER, 32'hFFFF_FFFF);
    send_item(CMD_WRITE, REG_CLK_SEL, 32'hFFFF_FFFF);
    send_item(CMD_WRITE, REG_CNT_BUF, 32'hFFFF_FFFF);
    send_item(CMD_WRITE, REG_COMPARE, 32'hFFFF_FFFF);
    send_item(CMD_WRITE, REG_COUNT, 32'h1234_5678);
    send_item(CMD_WRITE, REG_UNUSED, 32'hFFFF_FFFF);
    send_item(CMD_READ, REG_UNUSED, 32'h0);
    send_item(CMD_UNUSED, REG_CONTROL, 32'hFFFF_FFFF);
    send_item(CMD_WRITE, REG_INTERRUPT, 32'hFFFF_FFFF);
    // Fast autoreload from two, with the interrupt enabled.
    send_item(CMD_WRITE, REG_PRESCALER, 32'h0);
    send_item(CMD_WRITE, REG_CLK_SEL, 32'h0);
    send_item(CMD_WRITE, REG_CNT_BUF, 32'h2);
    send_item(CMD_WRITE, REG_CONTROL, CTL_START_M | CTL_MANUAL_M | CTL_AUTO_M);
    repeat (3) send_item(CMD_TICK, 3'h0, 32'h0);
    send_item(CMD_READ, REG_INTERRUPT, 32'h0);
    // Zero reload value expires on every tick.
    send_item(CMD_WRITE, REG_CNT_BUF, 32'h0);
    send_item(CMD_WRITE, REG_CONTROL, CTL_START_M | CTL_MANUAL_M | CTL_AUTO_M);
    send_item(CMD_TICK, 3'h0, 32'h0);
    // Without autoreload a zero counter expires at once and stops the timer.
    send_item(CMD_WRITE, REG_CONTROL, CTL_START_M);
    repeat (2) send_item(CMD_TICK, 3'h0, 32'h0);
    send_item(CMD_READ, REG_CONTROL, 32'h0);
    // Lowering the prescaler below the running count wraps it on the next tick.
    send_item(CMD_WRITE, REG_PRESCALER, 32'h5);
    send_item(CMD_WRITE, REG_CONTROL, CTL_START_M | CTL_MANUAL_M | CTL_AUTO_M);
    repeat (3) send_item(CMD_TICK, 3'h0, 32'h0);
    send_item(CMD_WRITE, REG_PRESCALER, 32'h1);
    send_item(CMD_TICK, 3'h0, 32'h0);
    send_item(CMD_WRITE, REG_INTERRUPT, INT_ST_M);
    drain();

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if (!paused && items_sent >= target - RANDOM_ITEMS / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 70) run_program();
      else run_noise();
    end
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver: random stalls, gap-free stretches, and one long hold that backs up the input.
  initial begin
    int loops;
    int gap;
    m_tready <= 1'b0;
    loops = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      loops++;
      if (loops == 400) gap = 200;
      else gap = idle_len((loops / 170) % 4 == 2);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

endmodule
